/* src/periodic_bspline_sampler_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the periodic B-spline sampler
// Short forms for clocked implications on clk with arst_n as the disable.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_BSPLINE_SAMPLER_ASSERT_SVH
`define PERIODIC_BSPLINE_SAMPLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBS_ASSERT_THEN(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PBS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/pbs_pkg.sv */
// ----------------------------------------------------------------------------
// pbs_pkg
// Types, codes and helpers shared by the periodic B-spline sampler modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pbs_pkg;

	localparam int MAX_CONTROLS_DEF = 64;
	localparam int T_FRAC_BITS_DEF  = 16;

	localparam int COORD_W = 24;
	localparam int IDX_W   = 16;
	localparam int NS_W    = 16;
	localparam logic [NS_W-1:0] NS_RESET = 16'd256;

	// Final divide by six: offset to make the value positive, then a
	// multiply by the rounded-up reciprocal 2^31/6.
	localparam int ROUND_OFS_EXP = 25;
	localparam int RECIP_SHIFT   = 31;
	localparam int RECIP_SIX     = 357913942;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_FEW   = 2'd1,
		STS_RANGE = 2'd2,
		STS_OVF   = 2'd3
	} status_t;

	typedef struct packed {
		logic                       opcode;
		logic                       start_new;
		logic signed [COORD_W-1:0]  coord_y;
		logic signed [COORD_W-1:0]  coord_x;
		logic [IDX_W-1:0]           sample_index;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0]  point_y;
		logic signed [COORD_W-1:0]  point_x;
		logic [1:0]                 status;
	} out_item_t;

	typedef enum logic [2:0] {
		MUL_NONE, MUL_KN, MUL_TT, MUL_T2T, MUL_WY, MUL_WX, MUL_RY, MUL_RX
	} mul_sel_t;

	typedef enum logic [2:0] {
		CAP_NONE, CAP_G, CAP_T2, CAP_T3, CAP_ACCY, CAP_ACCX, CAP_RESY, CAP_RESX
	} cap_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_MULG, ST_DLOAD, ST_DIV, ST_SQ, ST_T2, ST_CB, ST_T3, ST_WGT,
		ST_RD, ST_MY, ST_MX, ST_AX, ST_RY, ST_RX, ST_RXC, ST_FIN
	} state_t;

	typedef struct packed {
		logic       load;
		logic       start;
		mul_sel_t   mul_sel;
		cap_t       cap;
		logic       div_step;
		logic       wgt_load;
		logic       rd;
		logic [1:0] lane;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic is_sample;
		logic in_err;
	} sts_t;

	// Clamp a 28-bit signed value into the 24-bit coordinate range.
	function automatic logic signed [COORD_W-1:0] sat24(input logic signed [27:0] v);
		logic signed [27:0] hi;
		logic signed [27:0] lo;
		hi = 28'sd8388607;
		lo = -28'sd8388608;
		if (v > hi) begin
			return hi[COORD_W-1:0];
		end else if (v < lo) begin
			return lo[COORD_W-1:0];
		end
		return v[COORD_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* src/periodic_bspline_sampler.sv */
// ----------------------------------------------------------------------------
// periodic_bspline_sampler
// Closed uniform B-spline sampler with a control point table and an APB port.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  in        in_valid / in_ready    in_data (pbs_pkg::in_item_t)
//  out       out_valid / out_ready  out_data (pbs_pkg::out_item_t)
//  config    psel/penable/pwrite    paddr, pwdata, prdata (num_samples at 0)
//
// A load transaction is written to the table without leaving idle. A flagged
// sample goes straight to the result stage; a good sample first runs through
// the radix-2 divider and the shared multiplier.
// One transaction is worked on at a time; a finished result waits in the
// output register while the next transaction is taken.
// Reset empties the table and sets num_samples to 256.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module periodic_bspline_sampler #(
	parameter int MAX_CONTROLS = pbs_pkg::MAX_CONTROLS_DEF,
	parameter int T_FRAC_BITS  = pbs_pkg::T_FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire pbs_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output pbs_pkg::out_item_t      out_data,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	import pbs_pkg::*;

	logic [NS_W-1:0] num_samples_q;
	cmd_t cmd;
	sts_t sts;

	// Configuration register.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_samples_q <= NS_RESET;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			num_samples_q <= pwdata[NS_W-1:0];
		end
	end
	assign prdata = paddr[2] ? '0 : 32'(num_samples_q);

	pbs_ctrl #(
		.MAX_CONTROLS(MAX_CONTROLS),
		.T_FRAC_BITS (T_FRAC_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pbs_dp #(
		.MAX_CONTROLS(MAX_CONTROLS),
		.T_FRAC_BITS (T_FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_data    (in_data),
		.num_samples(num_samples_q),
		.cmd        (cmd),
		.sts        (sts),
		.out_data   (out_data)
	);

endmodule

`default_nettype wire

/* src/pbs_dp.sv */
// ----------------------------------------------------------------------------
// pbs_dp
// Datapath: control point table, radix-2 divider, shared multiplier,
// basis weights, accumulators and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "periodic_bspline_sampler_assert.svh"

module pbs_dp #(
	parameter int MAX_CONTROLS = pbs_pkg::MAX_CONTROLS_DEF,
	parameter int T_FRAC_BITS  = pbs_pkg::T_FRAC_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire pbs_pkg::in_item_t       in_data,
	input  wire logic [pbs_pkg::NS_W-1:0] num_samples,
	input  wire pbs_pkg::cmd_t           cmd,
	output pbs_pkg::sts_t                sts,
	output pbs_pkg::out_item_t           out_data
);
	import pbs_pkg::*;

	localparam int TF   = T_FRAC_BITS;
	localparam int CW   = $clog2(MAX_CONTROLS + 1);
	localparam int AW   = $clog2(MAX_CONTROLS);
	localparam int GW   = IDX_W + CW;
	localparam int DW   = GW + TF;
	localparam int WW   = TF + 4;
	localparam int PW   = WW + COORD_W;
	localparam int ACW  = PW + 2;
	localparam int MOPW = 33;
	localparam int PRW  = 2 * MOPW;
	localparam int UW   = 29;

	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_CONTROLS);
	localparam logic signed [ACW-1:0] HALF_DIV = ACW'(3) << TF;
	localparam logic signed [29:0] POS_OFS = 30'(6) << ROUND_OFS_EXP;
	localparam logic signed [27:0] Q_OFS = 28'(1) << ROUND_OFS_EXP;

	// Control point table and contour bookkeeping.
	logic [2*COORD_W-1:0] mem [MAX_CONTROLS];
	logic [CW-1:0] count_q;
	logic ovf_q;
	logic mem_we;
	logic [AW-1:0] mem_wa;

	// Per-sample registers.
	logic [IDX_W-1:0] k_q;
	logic [CW-1:0] n_q;
	status_t stat_q;
	logic [DW-1:0] dvd_q;
	logic [NS_W-1:0] rem_q;
	logic [TF-1:0] t2_q;
	logic [TF-1:0] t3_q;
	logic signed [WW-1:0] w_q [4];
	logic [AW-1:0] idx_q;
	logic [2*COORD_W-1:0] rd_q;
	logic signed [PRW-1:0] prod_q;
	logic signed [ACW-1:0] acc_y_q;
	logic signed [ACW-1:0] acc_x_q;
	logic signed [COORD_W-1:0] res_y_q;
	logic signed [COORD_W-1:0] res_x_q;
	out_item_t out_q;

	status_t err_code;
	logic [TF-1:0] t_cur;
	logic [CW-1:0] seg;
	logic [AW-1:0] idx0;
	logic [AW-1:0] idx_nxt;
	logic signed [WW-1:0] w_new [4];
	logic signed [MOPW-1:0] op_a;
	logic signed [MOPW-1:0] op_b;
	logic [NS_W:0] rem_sh;
	logic rem_ge;
	logic [UW-1:0] u_y;
	logic [UW-1:0] u_x;
	logic signed [27:0] q_diff;

	// Status of a new sample transaction, by priority.
	always_comb begin
		if (ovf_q) begin
			err_code = STS_OVF;
		end else if (count_q < CW'(2)) begin
			err_code = STS_FEW;
		end else if (in_data.sample_index >= num_samples) begin
			err_code = STS_RANGE;
		end else begin
			err_code = STS_OK;
		end
	end

	assign sts.is_sample = (in_data.opcode == OP_SAMPLE);
	assign sts.in_err    = (err_code != STS_OK);

	// Load transactions: append or restart the contour.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		if (cmd.load) begin
			if (in_data.start_new) begin
				mem_we = 1'b1;
			end else if (count_q < MAX_CNT) begin
				mem_we = 1'b1;
				mem_wa = count_q[AW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.load) begin
			if (in_data.start_new) begin
				count_q <= CW'(1);
				ovf_q   <= 1'b0;
			end else if (count_q < MAX_CNT) begin
				count_q <= count_q + CW'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// Table write and registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= {in_data.coord_y, in_data.coord_x};
		end
		if (cmd.rd) begin
			rd_q <= mem[idx_q];
		end
	end

	// Divider step: restoring, one quotient bit per cycle.
	assign rem_sh = {rem_q, dvd_q[DW-1]};
	assign rem_ge = (rem_sh >= {1'b0, num_samples});

	// Segment, local parameter and first control index.
	assign t_cur = dvd_q[TF-1:0];
	assign seg   = dvd_q[TF +: CW];
	assign idx0  = (seg == '0) ? AW'(n_q - CW'(1)) : AW'(seg - CW'(1));
	assign idx_nxt = (CW'(idx_q) == n_q - CW'(1)) ? '0 : idx_q + AW'(1);

	// Basis weights, scaled by 6T in total.
	always_comb begin
		logic signed [WW-1:0] tt;
		logic signed [WW-1:0] s2;
		logic signed [WW-1:0] s3;
		logic signed [WW-1:0] one;
		tt  = WW'(t_cur);
		s2  = WW'(t2_q);
		s3  = WW'(t3_q);
		one = WW'(1) << TF;
		if (n_q == CW'(2)) begin
			w_new[0] = '0;
			w_new[1] = WW'(6) * (one - tt);
			w_new[2] = WW'(6) * tt;
			w_new[3] = '0;
		end else if (n_q == CW'(3)) begin
			w_new[0] = WW'(3) * (one - WW'(2) * tt + s2);
			w_new[1] = WW'(3) * (one + WW'(2) * tt - WW'(2) * s2);
			w_new[2] = WW'(3) * s2;
			w_new[3] = '0;
		end else begin
			w_new[0] = one - WW'(3) * tt + WW'(3) * s2 - s3;
			w_new[1] = WW'(4) * one - WW'(6) * s2 + WW'(3) * s3;
			w_new[2] = one + WW'(3) * tt + WW'(3) * s2 - WW'(3) * s3;
			w_new[3] = s3;
		end
	end

	// Rounding: floor((acc + 3T) / T), made positive for the divide by six.
	always_comb begin
		logic signed [ACW-1:0] ry;
		logic signed [ACW-1:0] rx;
		logic signed [29:0] vy;
		logic signed [29:0] vx;
		ry  = (acc_y_q + HALF_DIV) >>> TF;
		rx  = (acc_x_q + HALF_DIV) >>> TF;
		vy  = ry[29:0] + POS_OFS;
		vx  = rx[29:0] + POS_OFS;
		u_y = vy[UW-1:0];
		u_x = vx[UW-1:0];
	end

	assign q_diff = $signed({1'b0, prod_q[RECIP_SHIFT +: 27]}) - Q_OFS;

	// Operand selection for the shared multiplier.
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (cmd.mul_sel)
			MUL_KN: begin
				op_a = MOPW'(k_q);
				op_b = MOPW'(n_q);
			end
			MUL_TT: begin
				op_a = MOPW'(t_cur);
				op_b = MOPW'(t_cur);
			end
			MUL_T2T: begin
				op_a = MOPW'(t2_q);
				op_b = MOPW'(t_cur);
			end
			MUL_WY: begin
				op_a = MOPW'(w_q[cmd.lane]);
				op_b = MOPW'($signed(rd_q[2*COORD_W-1:COORD_W]));
			end
			MUL_WX: begin
				op_a = MOPW'(w_q[cmd.lane]);
				op_b = MOPW'($signed(rd_q[COORD_W-1:0]));
			end
			MUL_RY: begin
				op_a = MOPW'(u_y);
				op_b = MOPW'(RECIP_SIX);
			end
			MUL_RX: begin
				op_a = MOPW'(u_x);
				op_b = MOPW'(RECIP_SIX);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// Product register and the captures that follow it.
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
		if (cmd.start) begin
			k_q    <= in_data.sample_index;
			n_q    <= count_q;
			stat_q <= err_code;
		end
		if (cmd.div_step) begin
			rem_q <= rem_ge ? NS_W'(rem_sh - {1'b0, num_samples}) : rem_sh[NS_W-1:0];
			dvd_q <= {dvd_q[DW-2:0], rem_ge};
		end
		if (cmd.wgt_load) begin
			for (int i = 0; i < 4; i++) begin
				w_q[i] <= w_new[i];
			end
			idx_q   <= idx0;
			acc_y_q <= '0;
			acc_x_q <= '0;
		end
		if (cmd.rd) begin
			idx_q <= idx_nxt;
		end
		case (cmd.cap)
			CAP_G: begin
				dvd_q <= {prod_q[GW-1:0], {TF{1'b0}}};
				rem_q <= '0;
			end
			CAP_T2: t2_q <= prod_q[TF +: TF];
			CAP_T3: t3_q <= prod_q[TF +: TF];
			CAP_ACCY: acc_y_q <= acc_y_q + ACW'($signed(prod_q[PW-1:0]));
			CAP_ACCX: acc_x_q <= acc_x_q + ACW'($signed(prod_q[PW-1:0]));
			CAP_RESY: res_y_q <= sat24(q_diff);
			CAP_RESX: res_x_q <= sat24(q_diff);
			default: begin
			end
		endcase
		if (cmd.out_load) begin
			out_q.status  <= stat_q;
			out_q.point_y <= (stat_q == STS_OK) ? res_y_q : '0;
			out_q.point_x <= (stat_q == STS_OK) ? res_x_q : '0;
		end
	end

	assign out_data = out_q;

	// Checks.
	`PBS_ASSERT_THEN(a_ovf_full, ovf_q, count_q == MAX_CNT, "overflow without a full table")
	`PBS_ASSERT_THEN(a_rem_range, cmd.div_step, rem_q < num_samples, "divider remainder out of range")
	`PBS_ASSERT_THEN(a_idx_range, cmd.rd, CW'(idx_q) < n_q, "control index beyond the point count")

endmodule

`default_nettype wire

/* src/pbs_ctrl.sv */
// ----------------------------------------------------------------------------
// pbs_ctrl
// Controller: sequences loads and samples through the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "periodic_bspline_sampler_assert.svh"

module pbs_ctrl #(
	parameter int MAX_CONTROLS = pbs_pkg::MAX_CONTROLS_DEF,
	parameter int T_FRAC_BITS  = pbs_pkg::T_FRAC_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire pbs_pkg::sts_t sts,
	output pbs_pkg::cmd_t      cmd
);
	import pbs_pkg::*;

	localparam int CW        = $clog2(MAX_CONTROLS + 1);
	localparam int DIV_STEPS = IDX_W + CW + T_FRAC_BITS;
	localparam int CNTW      = $clog2(DIV_STEPS);
	localparam logic [CNTW-1:0] DIV_LAST  = CNTW'(DIV_STEPS - 1);
	localparam logic [CNTW-1:0] LANE_LAST = CNTW'(3);

	state_t state_q;
	state_t state_nxt;
	logic [CNTW-1:0] cnt_q;
	logic out_valid_q;
	logic in_fire;
	logic out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && sts.is_sample) begin
					state_nxt = sts.in_err ? ST_FIN : ST_MULG;
				end
			end
			ST_MULG:  state_nxt = ST_DLOAD;
			ST_DLOAD: state_nxt = ST_DIV;
			ST_DIV: begin
				if (cnt_q == DIV_LAST) begin
					state_nxt = ST_SQ;
				end
			end
			ST_SQ:  state_nxt = ST_T2;
			ST_T2:  state_nxt = ST_CB;
			ST_CB:  state_nxt = ST_T3;
			ST_T3:  state_nxt = ST_WGT;
			ST_WGT: state_nxt = ST_RD;
			ST_RD:  state_nxt = ST_MY;
			ST_MY:  state_nxt = ST_MX;
			ST_MX:  state_nxt = ST_AX;
			ST_AX: begin
				state_nxt = (cnt_q == LANE_LAST) ? ST_RY : ST_RD;
			end
			ST_RY:  state_nxt = ST_RX;
			ST_RX:  state_nxt = ST_RXC;
			ST_RXC: state_nxt = ST_FIN;
			ST_FIN: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd          = '0;
		cmd.mul_sel  = MUL_NONE;
		cmd.cap      = CAP_NONE;
		cmd.lane     = cnt_q[1:0];
		case (state_q)
			ST_IDLE: begin
				cmd.load  = in_fire && !sts.is_sample;
				cmd.start = in_fire && sts.is_sample;
			end
			ST_MULG:  cmd.mul_sel = MUL_KN;
			ST_DLOAD: cmd.cap = CAP_G;
			ST_DIV:   cmd.div_step = 1'b1;
			ST_SQ:    cmd.mul_sel = MUL_TT;
			ST_T2:    cmd.cap = CAP_T2;
			ST_CB:    cmd.mul_sel = MUL_T2T;
			ST_T3:    cmd.cap = CAP_T3;
			ST_WGT:   cmd.wgt_load = 1'b1;
			ST_RD:    cmd.rd = 1'b1;
			ST_MY:    cmd.mul_sel = MUL_WY;
			ST_MX: begin
				cmd.mul_sel = MUL_WX;
				cmd.cap     = CAP_ACCY;
			end
			ST_AX:    cmd.cap = CAP_ACCX;
			ST_RY:    cmd.mul_sel = MUL_RY;
			ST_RX: begin
				cmd.mul_sel = MUL_RX;
				cmd.cap     = CAP_RESY;
			end
			ST_RXC:   cmd.cap = CAP_RESX;
			ST_FIN:   cmd.out_load = out_free;
			default: begin
			end
		endcase
	end

	// State, step counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_DLOAD || state_q == ST_WGT) begin
				cnt_q <= '0;
			end else if (state_q == ST_DIV || state_q == ST_AX) begin
				cnt_q <= cnt_q + CNTW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Checks.
	`PBS_ASSERT_NEXT(a_out_loaded, cmd.out_load, out_valid_q, "result loaded but not shown")
	`PBS_ASSERT_NEXT(a_div_done, state_q == ST_DIV && cnt_q == DIV_LAST, state_q == ST_SQ, "divider overran")
	`PBS_ASSERT_NEXT(a_load_idle, in_fire && !sts.is_sample, state_q == ST_IDLE, "load left idle")

endmodule

`default_nettype wire

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// Periodic B-spline sampler testbench
// Loads closed contours, requests curve samples and checks every result
// against a bit-accurate predictor kept inside the bench, under random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import pbs_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam int LATENCY     = 100;
	localparam int CYCLE_LIMIT = 600000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Predictor state: contour table, point count, overflow and sample count.
	logic signed [COORD_W-1:0] pred_y_tab [TABLE_DEPTH];
	logic signed [COORD_W-1:0] pred_x_tab [TABLE_DEPTH];
	int unsigned               pred_count;
	bit                        pred_ovf;
	int unsigned               pred_samples;

	out_item_t   curve_expect_q[$];
	int          mismatch_count;
	int          cycle_count;
	bit          stall_enable;
	int          items_sent;

	periodic_bspline_sampler u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// Clock with a 2 ns period.
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Rounded divide by 6T, half toward plus infinity, then 24-bit clamp.
	function automatic logic signed [COORD_W-1:0] round_clamp(longint acc);
		longint d;
		longint y;
		longint q;
		d = 6 * (longint'(1) << 16);
		y = acc + d / 2;
		if (y >= 0) begin
			q = y / d;
		end else begin
			q = -((-y + d - 1) / d);
		end
		if (q > 8388607) begin
			q = 8388607;
		end
		if (q < -8388608) begin
			q = -8388608;
		end
		return q[COORD_W-1:0];
	endfunction

	// Apply one transaction to the predictor; returns 1 when a result follows.
	function automatic bit predict_curve(input in_item_t it, output out_item_t res);
		longint      tt;
		longint      t;
		longint      t2;
		longint      t3;
		longint      w [4];
		longint      acc_y;
		longint      acc_x;
		longint unsigned g;
		int unsigned seg;
		int unsigned rem;
		int unsigned n;
		int unsigned idx;
		res = '0;
		tt = longint'(1) << 16;
		if (it.opcode == OP_LOAD) begin
			if (it.start_new) begin
				pred_count = 0;
				pred_ovf = 1'b0;
			end
			if (pred_count < TABLE_DEPTH) begin
				pred_y_tab[pred_count] = it.coord_y;
				pred_x_tab[pred_count] = it.coord_x;
				pred_count++;
			end else begin
				pred_ovf = 1'b1;
			end
			return 1'b0;
		end
		if (pred_ovf) begin
			res.status = STS_OVF;
			return 1'b1;
		end
		if (pred_count < 2) begin
			res.status = STS_FEW;
			return 1'b1;
		end
		if (it.sample_index >= pred_samples) begin
			res.status = STS_RANGE;
			return 1'b1;
		end
		n = pred_count;
		g = longint'(it.sample_index) * n;
		seg = 32'(g / pred_samples);
		rem = 32'(g % pred_samples);
		t = (longint'(rem) << 16) / pred_samples;
		t2 = (t * t) >>> 16;
		t3 = (t2 * t) >>> 16;
		w[0] = 0;
		w[1] = 0;
		w[2] = 0;
		w[3] = 0;
		if (n == 2) begin
			w[1] = 6 * (tt - t);
			w[2] = 6 * t;
		end else if (n == 3) begin
			w[0] = 3 * (tt - 2 * t + t2);
			w[1] = 3 * (tt + 2 * t - 2 * t2);
			w[2] = 3 * t2;
		end else begin
			w[0] = tt - 3 * t + 3 * t2 - t3;
			w[1] = 4 * tt - 6 * t2 + 3 * t3;
			w[2] = tt + 3 * t + 3 * t2 - 3 * t3;
			w[3] = t3;
		end
		acc_y = 0;
		acc_x = 0;
		for (int i = 0; i < 4; i++) begin
			idx = (seg + n + i - 1) % n;
			acc_y += w[i] * longint'(pred_y_tab[idx]);
			acc_x += w[i] * longint'(pred_x_tab[idx]);
		end
		res.point_y = round_clamp(acc_y);
		res.point_x = round_clamp(acc_x);
		res.status = STS_OK;
		return 1'b1;
	endfunction

	// Input monitor: predict on each accepted transaction.
	always @(posedge clk) begin
		out_item_t res;
		if (arst_n && in_valid && in_ready) begin
			if (predict_curve(in_data, res)) begin
				curve_expect_q = {curve_expect_q, res};
			end
		end
	end

	// Output checker: compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (curve_expect_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("Unexpected result y=%0d x=%0d status=%0d",
						out_data.point_y, out_data.point_x, out_data.status);
				end
			end else begin
				want = curve_expect_q.pop_front();
				if (want.point_y !== out_data.point_y || want.point_x !== out_data.point_x
						|| want.status !== out_data.status) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("Result mismatch: expected y=%0d x=%0d status=%0d, got y=%0d x=%0d status=%0d",
							want.point_y, want.point_x, want.status,
							out_data.point_y, out_data.point_x, out_data.status);
					end
				end
			end
		end
	end

	// Cycle limit guards against a hang.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver side: ready drops in random bursts while stalls are enabled.
	initial begin
		int burst;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_enable && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 13);
				out_ready <= 1'b0;
				repeat (burst - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) begin
					repeat ($urandom_range(1, 20)) @(negedge clk);
				end
			end
		end
	end

	// Send one transaction, with an optional idle burst in front of it.
	task automatic send_item(input in_item_t it);
		if (stall_enable && $urandom_range(0, 4) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13) - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		do begin
			@(posedge clk);
		end while (!in_ready);
		items_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (curve_expect_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_samples(input int unsigned value);
		wait_drained();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'd0;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		pred_samples = value & 16'hFFFF;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic in_item_t make_item(input bit op, input bit st,
			input logic [23:0] y, input logic [23:0] x, input logic [15:0] k);
		in_item_t it;
		it.opcode = op;
		it.start_new = st;
		it.coord_y = y;
		it.coord_x = x;
		it.sample_index = k;
		return it;
	endfunction

	function automatic logic [23:0] rand_coord();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 3))
			0: return r[23:0];
			1: return {{8{r[15]}}, r[15:0]};
			2: return r[0] ? 24'h7FFFFF : 24'h800000;
			default: return {{12{r[11]}}, r[11:0]};
		endcase
	endfunction

	// Flags: no points, one point, index past the end.
	task automatic test_status_flags();
		send_item(make_item(OP_SAMPLE, 1'b0, 24'h0, 24'h0, 16'd0));
		send_item(make_item(OP_LOAD, 1'b1, 24'h000100, 24'hFFFF00, 16'hFFFF));
		send_item(make_item(OP_SAMPLE, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 16'd0));
		send_item(make_item(OP_LOAD, 1'b0, 24'h000200, 24'h000300, 16'd0));
		send_item(make_item(OP_SAMPLE, 1'b0, 24'h0, 24'h0, 16'd255));
		send_item(make_item(OP_SAMPLE, 1'b0, 24'h0, 24'h0, 16'd256));
		send_item(make_item(OP_SAMPLE, 1'b0, 24'h0, 24'h0, 16'hFFFF));
	endtask

	// Linear, quadratic and cubic contours at the coordinate extremes.
	task automatic test_degrees();
		for (int n = 2; n <= 4; n++) begin
			for (int i = 0; i < n; i++) begin
				send_item(make_item(OP_LOAD, i == 0, (i % 2) ? 24'h800000 : 24'h7FFFFF,
					(i % 2) ? 24'h7FFFFF : 24'h800000, 16'd0));
			end
			send_item(make_item(OP_SAMPLE, 1'b0, 24'h0, 24'h0, 16'd0));
			send_item(make_item(OP_SAMPLE, 1'b0, 24'h0, 24'h0, 16'd131));
			send_item(make_item(OP_SAMPLE, 1'b0, 24'h0, 24'h0, 16'd255));
		end
	endtask

	// Full table, a dropped append, then recovery on start-new.
	task automatic test_table_overflow();
		for (int i = 0; i <= TABLE_DEPTH; i++) begin
			send_item(make_item(OP_LOAD, i == 0, rand_coord(), rand_coord(), 16'd0));
		end
		send_item(make_item(OP_SAMPLE, 1'b0, 24'h0, 24'h0, 16'd10));
		send_item(make_item(OP_LOAD, 1'b1, rand_coord(), rand_coord(), 16'd0));
		send_item(make_item(OP_LOAD, 1'b0, rand_coord(), rand_coord(), 16'd0));
		send_item(make_item(OP_SAMPLE, 1'b0, 24'h0, 24'h0, 16'd77));
	endtask

	// Smallest and largest sample counts.
	task automatic test_sample_count_extremes();
		write_samples(1);
		send_item(make_item(OP_SAMPLE, 1'b0, 24'h0, 24'h0, 16'd0));
		send_item(make_item(OP_SAMPLE, 1'b0, 24'h0, 24'h0, 16'd1));
		write_samples(65535);
		send_item(make_item(OP_SAMPLE, 1'b0, 24'h0, 24'h0, 16'd0));
		send_item(make_item(OP_SAMPLE, 1'b0, 24'h0, 24'h0, 16'd65534));
		send_item(make_item(OP_SAMPLE, 1'b0, 24'h0, 24'h0, 16'd40000));
	endtask

	// Random contours and samples across several sample counts.
	task automatic test_random_contours();
		int unsigned counts [7];
		int          base;
		int          n;
		int          m;
		int unsigned ns;
		logic [15:0] k;
		counts = '{1, 2, 7, 256, 1000, 65535, 0};
		base = items_sent;
		while (items_sent - base < 340) begin
			ns = counts[$urandom_range(0, 6)];
			if (ns == 0) begin
				ns = $urandom_range(1, 65535);
			end
			write_samples(ns);
			if (items_sent - base > 280) begin
				stall_enable = 1'b0;
			end
			repeat ($urandom_range(1, 3)) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5, 6: n = $urandom_range(2, 6);
					7, 8: n = $urandom_range(7, 20);
					default: n = $urandom_range(0, 1) ? TABLE_DEPTH : TABLE_DEPTH + 2;
				endcase
				for (int i = 0; i < n; i++) begin
					send_item(make_item(OP_LOAD, i == 0, rand_coord(), rand_coord(),
						16'($urandom)));
				end
				m = $urandom_range(3, 10);
				for (int j = 0; j < m; j++) begin
					if ($urandom_range(0, 9) == 0) begin
						k = 16'($urandom);
					end else begin
						k = 16'($urandom_range(0, ns - 1));
					end
					if ($urandom_range(0, 19) == 0) begin
						send_item(make_item(OP_LOAD, $urandom_range(0, 3) == 0,
							rand_coord(), rand_coord(), k));
					end
					send_item(make_item(OP_SAMPLE, $urandom_range(0, 1), rand_coord(),
						rand_coord(), k));
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pred_count = 0;
		pred_ovf = 1'b0;
		pred_samples = 256;
		mismatch_count = 0;
		cycle_count = 0;
		items_sent = 0;
		stall_enable = 1'b1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_status_flags();
		test_degrees();
		test_table_overflow();
		test_sample_count_extremes();
		write_samples(256);
		test_random_contours();
		wait_drained();

		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
